// ===== rtl/mst_pkg.sv =====
// ----------------------------------------------------------------------------
// mst_pkg
// Shared types and codes for the multi-slot repeat timer.
// ----------------------------------------------------------------------------
`default_nettype none

package mst_pkg;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_SET   = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  localparam logic KIND_FIRE  = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  localparam int         CNT_W   = 4;
  localparam logic [3:0] MAX_OUT = 4'd8;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] interval;
    logic [31:0] last_call;
    logic [15:0] repeats;
  } entry_t;

  typedef struct packed {
    logic   wr;
    logic   en_set;
    logic   en_clr;
    entry_t data;
  } wr_t;

endpackage

`default_nettype wire

// ===== rtl/mst_slot_store.sv =====
// ----------------------------------------------------------------------------
// mst_slot_store
// Timer slot table: enable flags in flops, slot contents in a memory with
// one registered read port and one write port.
// ----------------------------------------------------------------------------
`default_nettype none

module mst_slot_store #(
  parameter int SLOTS  = 8,
  parameter int SLOT_W = 3
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [SLOT_W-1:0]   rd_addr,
  output mst_pkg::entry_t          rd_data,
  input  wire logic [SLOT_W-1:0]   wr_addr,
  input  wire mst_pkg::wr_t        wr,
  output logic      [SLOTS-1:0]    enabled
);

  mst_pkg::entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr.wr) begin
      mem[wr_addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= '0;
    end else if (wr.wr) begin
      if (wr.en_set) begin
        enabled[wr_addr] <= 1'b1;
      end else if (wr.en_clr) begin
        enabled[wr_addr] <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/multi_slot_repeat_timer_top.sv =====
// ----------------------------------------------------------------------------
// multi_slot_repeat_timer_top
// Table of repeating timer slots with tick, set and query commands.
// ----------------------------------------------------------------------------
// Each tick, set or query is worked by walking the slot table one slot at a
// time: the slot memory is read, then the slot is evaluated, and at the end
// any held firing is flushed or the reply is sent. A new item is taken only
// after the walk and its flush or reply are done, and the walk waits while
// the result side stalls. The single memory read port and the one 33-bit due
// adder/comparator are why it goes slot by slot. A tick emits its firings in
// slot order, at most 8; set and query emit one reply. Command 3 is accepted
// and dropped with no result. s_tready is high only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_slot_repeat_timer_top #(
  parameter int SLOTS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [95:0] s_tdata,   // now_ms, timer_id, interval_ms, repeat_count
  input  wire logic [1:0]  s_tuser,   // command
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // ok, slot, fired_id, repeats_left, pad
  output logic [0:0]       m_tuser,   // kind
  output logic             m_tlast
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_EVAL, S_FLUSH, S_REPLY} state_t;

  state_t state;

  logic [1:0]  cmd;
  logic [31:0] now;
  logic [15:0] tid;
  logic [31:0] ivl;
  logic [15:0] reps_in;

  logic [SLOT_W-1:0]     idx;
  logic [mst_pkg::CNT_W-1:0] n_out;
  logic                  pend_valid;
  logic [SLOT_W-1:0]     pend_slot;
  logic [15:0]           pend_id;
  logic [15:0]           pend_reps;
  logic                  hit_found;
  logic [SLOT_W-1:0]     hit_idx;
  logic [15:0]           hit_reps;
  logic                  free_found;
  logic [SLOT_W-1:0]     free_idx;

  logic                  out_kind;
  logic                  out_ok;
  logic [SLOT_W-1:0]     out_slot;
  logic [15:0]           out_id;
  logic [15:0]           out_reps;
  logic                  out_last;

  mst_pkg::entry_t       rd;
  mst_pkg::wr_t          wr;
  logic [SLOT_W-1:0]     wr_addr;
  logic [SLOTS-1:0]      enabled;

  logic [32:0]           due_sum;
  logic                  en_cur;
  logic                  fire;
  logic                  report;
  logic                  need_push;
  logic                  out_free;
  logic                  eval_go;
  logic [15:0]           new_reps;
  logic                  set_found;
  logic [SLOT_W-1:0]     set_slot;
  logic                  reply_go;
  logic                  push;
  logic [SLOT_W+2:0]     slot_ext;

  mst_slot_store #(.SLOTS(SLOTS), .SLOT_W(SLOT_W)) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (idx),
    .rd_data (rd),
    .wr_addr (wr_addr),
    .wr      (wr),
    .enabled (enabled)
  );

  assign s_tready  = (state == S_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign due_sum   = {1'b0, rd.last_call} + {1'b0, rd.interval};
  assign en_cur    = enabled[idx];
  assign fire      = (state == S_EVAL) && (cmd == mst_pkg::CMD_TICK) && en_cur &&
                     ({1'b0, now} >= due_sum);
  assign report    = fire && (n_out < mst_pkg::MAX_OUT);
  assign need_push = report && pend_valid;
  assign eval_go   = (state == S_EVAL) && (!need_push || out_free);
  assign new_reps  = (rd.repeats > 16'd1) ? rd.repeats - 16'd1 : 16'd0;
  assign set_found = hit_found || free_found;
  assign set_slot  = hit_found ? hit_idx : free_idx;
  assign reply_go  = (state == S_REPLY) && out_free;
  assign push      = (eval_go && need_push) ||
                     ((state == S_FLUSH) && pend_valid && out_free) || reply_go;

  always_comb begin
    wr      = '0;
    wr_addr = idx;
    if (fire && eval_go) begin
      wr.wr             = 1'b1;
      wr.en_clr         = (rd.repeats == 16'd1);
      wr.data.id        = rd.id;
      wr.data.interval  = rd.interval;
      wr.data.last_call = now;
      wr.data.repeats   = new_reps;
    end else if (reply_go && (cmd == mst_pkg::CMD_SET) && set_found) begin
      wr.wr             = 1'b1;
      wr.en_set         = 1'b1;
      wr.data.id        = tid;
      wr.data.interval  = ivl;
      wr.data.last_call = now;
      wr.data.repeats   = reps_in;
      wr_addr           = set_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      m_tvalid   <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (push) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd        <= s_tuser;
            now        <= s_tdata[31:0];
            tid        <= s_tdata[47:32];
            ivl        <= s_tdata[79:48];
            reps_in    <= s_tdata[95:80];
            idx        <= '0;
            n_out      <= '0;
            pend_valid <= 1'b0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            if (s_tuser inside {mst_pkg::CMD_TICK, mst_pkg::CMD_SET, mst_pkg::CMD_QUERY}) begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (eval_go) begin
            if (cmd != mst_pkg::CMD_TICK) begin
              if (en_cur && (rd.id == tid) && !hit_found) begin
                hit_found <= 1'b1;
                hit_idx   <= idx;
                hit_reps  <= rd.repeats;
              end
              if (!en_cur && !free_found) begin
                free_found <= 1'b1;
                free_idx   <= idx;
              end
            end
            if (report) begin
              if (pend_valid) begin
                out_kind <= mst_pkg::KIND_FIRE;
                out_ok   <= 1'b1;
                out_slot <= pend_slot;
                out_id   <= pend_id;
                out_reps <= pend_reps;
                out_last <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_slot  <= idx;
              pend_id    <= rd.id;
              pend_reps  <= new_reps;
              n_out      <= n_out + 1'b1;
            end
            if (idx == LAST_IDX) begin
              state <= (cmd == mst_pkg::CMD_TICK) ? S_FLUSH : S_REPLY;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_READ;
            end
          end
        end
        S_FLUSH: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_kind   <= mst_pkg::KIND_FIRE;
            out_ok     <= 1'b1;
            out_slot   <= pend_slot;
            out_id     <= pend_id;
            out_reps   <= pend_reps;
            out_last   <= 1'b1;
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        S_REPLY: begin
          if (out_free) begin
            out_kind <= mst_pkg::KIND_REPLY;
            out_id   <= tid;
            out_last <= 1'b1;
            if (cmd == mst_pkg::CMD_SET) begin
              out_ok   <= set_found;
              out_slot <= set_found ? set_slot : '0;
              out_reps <= set_found ? reps_in : 16'd0;
            end else begin
              out_ok   <= hit_found;
              out_slot <= hit_found ? hit_idx : '0;
              out_reps <= hit_found ? hit_reps : 16'd0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign slot_ext = {3'b000, out_slot};
  assign m_tdata  = {4'd0, out_reps, out_id, slot_ext[2:0], out_ok};
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

endmodule

`default_nettype wire

// ===== rtl/mst_checker.sv =====
// ----------------------------------------------------------------------------
// mst_checker
// Port-level checks for the multi-slot repeat timer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mst_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [1:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic [0:0]  m_tuser,
  input wire logic        m_tlast
);

  // a working command keeps the block busy for the slot walk
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser != mst_pkg::CMD_NONE) |=> !s_tready)
    else $error("block ready right after accepting a command");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  a_fire_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[0] == mst_pkg::KIND_FIRE) |-> m_tdata[0])
    else $error("firing item without ok");

  a_fail_reply: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[0] == mst_pkg::KIND_REPLY) && !m_tdata[0]
      |-> (m_tdata[3:1] == 3'd0) && (m_tdata[35:20] == 16'd0))
    else $error("failed reply carries slot or repeat count");

  a_reply_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[0] == mst_pkg::KIND_REPLY) |-> m_tlast)
    else $error("reply not marked last");

endmodule

bind multi_slot_repeat_timer_top mst_checker u_mst_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire
